// ===== hw/rtl/bge_pkg.sv =====
// Shared types, action codes and sizes of the bit-vector gate evaluator.
package bge_pkg;

   localparam int WORD_BITS = 64;
   localparam int OFF_BITS  = 16;
   localparam int CNT_BITS  = 7;
   localparam int ACT_BITS  = 4;

   localparam logic [ACT_BITS-1:0] ACT_COPY   = 4'd0;
   localparam logic [ACT_BITS-1:0] ACT_NOT    = 4'd1;
   localparam logic [ACT_BITS-1:0] ACT_AND    = 4'd2;
   localparam logic [ACT_BITS-1:0] ACT_NAND   = 4'd3;
   localparam logic [ACT_BITS-1:0] ACT_OR     = 4'd4;
   localparam logic [ACT_BITS-1:0] ACT_NOR    = 4'd5;
   localparam logic [ACT_BITS-1:0] ACT_XOR    = 4'd6;
   localparam logic [ACT_BITS-1:0] ACT_XNOR   = 4'd7;
   localparam logic [ACT_BITS-1:0] ACT_DLATCH = 4'd8;
   localparam logic [ACT_BITS-1:0] ACT_LOAD   = 4'd9;
   localparam logic [ACT_BITS-1:0] ACT_READ   = 4'd10;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_MOD,
      ST_RDAB,
      ST_RDC,
      ST_WR,
      ST_LOAD,
      ST_RDW,
      ST_RDW_WAIT,
      ST_DONE
   } state_type;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic clr_en;
      logic mod_step;
      logic rd_ab;
      logic rd_c;
      logic wr_bit;
      logic load_wr;
      logic rd_word;
      logic rd_word_cap;
      logic finish;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic clr_last;
      logic mod_last;
      logic bit_last;
      logic n_zero;
      logic is_gate;
      logic is_load;
      logic is_read;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/bge_ram.sv =====
// Generic RAM, one write port and two registered read ports.
module bge_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr0,
   output logic [WIDTH-1:0]                          rdata0,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr1,
   output logic [WIDTH-1:0]                          rdata1
);

   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata0 <= mem[raddr0];
      rdata1 <= mem[raddr1];
   end

endmodule

// ===== hw/rtl/bge_ctrl.sv =====
// Sequencer of the gate evaluator: clear pass, offset wrap, bit loop or word load/read, result.
module bge_ctrl import bge_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_tvalid,
   output logic       req_tready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and commands
   always_comb begin
      state_in   = state_ff;
      cmd        = '0;
      req_tready = 1'b0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_en = 1'b1;
            if (status.clr_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = ST_MOD;
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            if (status.mod_last) begin
               priority if (status.is_gate) begin
                  state_in = status.n_zero ? ST_DONE : ST_RDAB;
               end else if (status.is_load) begin
                  state_in = ST_LOAD;
               end else if (status.is_read) begin
                  state_in = ST_RDW;
               end else begin
                  state_in = ST_DONE;
               end
            end
         end
         ST_RDAB: begin
            cmd.rd_ab = 1'b1;
            state_in  = ST_RDC;
         end
         ST_RDC: begin
            cmd.rd_c = 1'b1;
            state_in = ST_WR;
         end
         ST_WR: begin
            cmd.wr_bit = 1'b1;
            state_in   = status.bit_last ? ST_DONE : ST_RDAB;
         end
         ST_LOAD: begin
            cmd.load_wr = 1'b1;
            state_in    = ST_DONE;
         end
         ST_RDW: begin
            cmd.rd_word = 1'b1;
            state_in    = ST_RDW_WAIT;
         end
         ST_RDW_WAIT: begin
            cmd.rd_word_cap = 1'b1;
            state_in        = ST_DONE;
         end
         ST_DONE: begin
            if (status.out_free) begin
               cmd.finish = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

endmodule

// ===== hw/rtl/bge_datapath.sv =====
// Operand registers, offset wrap, wire memory, bit update and result register.
module bge_datapath import bge_pkg::*; #(
   parameter int WIRE_WORDS = 1024,
   parameter int MAX_WIDTH  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  cmd_type              cmd,
   output status_type           status,
   input  logic [119:0]         req_tdata,
   input  logic [ACT_BITS-1:0]  req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   output logic [WORD_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   localparam int AW = (WIRE_WORDS > 1) ? $clog2(WIRE_WORDS) : 1;
   localparam logic [32:0] WW33 = 33'(WIRE_WORDS);
   localparam logic [16:0] WLAST = 17'(WIRE_WORDS - 1);
   localparam logic [CNT_BITS-1:0] NMAX = CNT_BITS'(MAX_WIDTH);
   // floor(2^32 / WIRE_WORDS)
   localparam logic [32:0] RECIP = 33'((64'd1 << 32) / 64'(WIRE_WORDS));

   // gate registers
   logic [ACT_BITS-1:0]  act_ff;
   logic [CNT_BITS-1:0]  n_ff, n_in, j_ff;
   logic [WORD_BITS-1:0] data_ff, res_ff, out_ff;
   logic                 last_ff, out_last_ff, out_valid_ff;
   logic [OFF_BITS-1:0]  ra_ff, rb_ff, rc_ff, ra_in, rb_in, rc_in;
   logic [OFF_BITS-1:0]  qa_ff, qb_ff, qc_ff;
   logic [5:0]           abit_ff, bbit_ff, cbit_ff;
   logic [1:0]           step_ff;
   logic [16:0]          clr_ff;
   logic                 x_ff, y_ff;

   logic [WORD_BITS-1:0] rd0, rd1, wdata, new_word;
   logic [AW-1:0]        waddr, raddr0;
   logic                 we, r_bit, c_old;

   // final correction of the word index reduction
   function automatic logic [OFF_BITS-1:0] mod_sub(input logic [OFF_BITS-1:0] r,
                                                   input logic [32:0] s);
      logic [32:0] w;
      w = 33'(r);
      return (w >= s) ? OFF_BITS'(w - s) : r;
   endfunction

   // quotient estimate by reciprocal multiply, at most one below the true quotient
   function automatic logic [OFF_BITS-1:0] recip_quot(input logic [OFF_BITS-1:0] r);
      logic [48:0] p;
      p = 49'(r) * 49'(RECIP);
      return p[47:32];
   endfunction

   // remainder left by the quotient estimate, below twice the word count
   function automatic logic [OFF_BITS-1:0] rem_est(input logic [OFF_BITS-1:0] r,
                                                   input logic [OFF_BITS-1:0] q);
      logic [32:0] p;
      p = 33'(q) * WW33;
      return r - p[OFF_BITS-1:0];
   endfunction

   // next word with wrap
   function automatic logic [OFF_BITS-1:0] next_word(input logic [OFF_BITS-1:0] r);
      return (17'(r) == WLAST) ? '0 : OFF_BITS'(17'(r) + 17'd1);
   endfunction

   assign ra_in   = (step_ff == 2'd1) ? rem_est(ra_ff, qa_ff) : mod_sub(ra_ff, WW33);
   assign rb_in   = (step_ff == 2'd1) ? rem_est(rb_ff, qb_ff) : mod_sub(rb_ff, WW33);
   assign rc_in   = (step_ff == 2'd1) ? rem_est(rc_ff, qc_ff) : mod_sub(rc_ff, WW33);
   assign n_in    = (req_tdata[54:48] > NMAX) ? NMAX : req_tdata[54:48];

   // status
   assign status.clr_last = (clr_ff == WLAST);
   assign status.mod_last = (step_ff == 2'd0);
   assign status.bit_last = (CNT_BITS'(j_ff + 7'd1) == n_ff);
   assign status.n_zero   = (n_ff == '0);
   assign status.is_gate  = (act_ff <= ACT_DLATCH);
   assign status.is_load  = (act_ff == ACT_LOAD);
   assign status.is_read  = (act_ff == ACT_READ);
   assign status.out_free = !out_valid_ff || rsp_tready;

   // gate function on the current bit
   assign c_old = rd0[cbit_ff];
   always_comb begin
      unique case (act_ff)
         ACT_COPY:   r_bit = x_ff;
         ACT_NOT:    r_bit = !x_ff;
         ACT_AND:    r_bit = x_ff & y_ff;
         ACT_NAND:   r_bit = !(x_ff & y_ff);
         ACT_OR:     r_bit = x_ff | y_ff;
         ACT_NOR:    r_bit = !(x_ff | y_ff);
         ACT_XOR:    r_bit = x_ff ^ y_ff;
         ACT_XNOR:   r_bit = !(x_ff ^ y_ff);
         ACT_DLATCH: r_bit = y_ff ? x_ff : c_old;
         default:    r_bit = c_old;
      endcase
      new_word          = rd0;
      new_word[cbit_ff] = r_bit;
   end

   // memory port muxing
   always_comb begin
      we     = cmd.clr_en | cmd.load_wr | cmd.wr_bit;
      waddr  = rc_ff[AW-1:0];
      wdata  = new_word;
      raddr0 = rc_ff[AW-1:0];
      priority if (cmd.clr_en) begin
         waddr = clr_ff[AW-1:0];
         wdata = '0;
      end else if (cmd.load_wr) begin
         wdata = data_ff;
      end
      if (cmd.rd_ab) raddr0 = ra_ff[AW-1:0];
   end

   bge_ram #(.WIDTH(WORD_BITS), .DEPTH(WIRE_WORDS)) u_ram (
      .clock  (clock),
      .we     (we),
      .waddr  (waddr),
      .wdata  (wdata),
      .raddr0 (raddr0),
      .rdata0 (rd0),
      .raddr1 (rb_ff[AW-1:0]),
      .rdata1 (rd1)
   );

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         if (cmd.clr_en) clr_ff <= 17'(clr_ff + 17'd1);
         if (cmd.finish) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         act_ff  <= req_tuser;
         n_ff    <= n_in;
         data_ff <= req_tdata[118:55];
         last_ff <= req_tlast;
         ra_ff   <= {6'd0, req_tdata[15:6]};
         rb_ff   <= {6'd0, req_tdata[31:22]};
         rc_ff   <= (req_tuser <= ACT_DLATCH) ? {6'd0, req_tdata[47:38]} : req_tdata[47:32];
         abit_ff <= req_tdata[5:0];
         bbit_ff <= req_tdata[21:16];
         cbit_ff <= req_tdata[37:32];
         step_ff <= 2'd2;
         j_ff    <= '0;
         res_ff  <= '0;
      end
      // word index reduction: quotient, remainder, correction
      if (cmd.mod_step) begin
         if (step_ff == 2'd2) begin
            qa_ff <= recip_quot(ra_ff);
            qb_ff <= recip_quot(rb_ff);
            qc_ff <= recip_quot(rc_ff);
         end else begin
            ra_ff <= ra_in;
            rb_ff <= rb_in;
            rc_ff <= rc_in;
         end
         step_ff <= 2'(step_ff - 2'd1);
      end
      if (cmd.rd_c) begin
         x_ff <= rd0[abit_ff];
         y_ff <= rd1[bbit_ff];
      end
      if (cmd.wr_bit) begin
         res_ff[j_ff[5:0]] <= r_bit;
         j_ff    <= CNT_BITS'(j_ff + 7'd1);
         abit_ff <= 6'(abit_ff + 6'd1);
         bbit_ff <= 6'(bbit_ff + 6'd1);
         cbit_ff <= 6'(cbit_ff + 6'd1);
         if (abit_ff == 6'd63) ra_ff <= next_word(ra_ff);
         if (bbit_ff == 6'd63) rb_ff <= next_word(rb_ff);
         if (cbit_ff == 6'd63) rc_ff <= next_word(rc_ff);
      end
      if (cmd.load_wr)     res_ff <= data_ff;
      if (cmd.rd_word_cap) res_ff <= rd0;
      if (cmd.finish) begin
         out_ff      <= res_ff;
         out_last_ff <= last_ff;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = out_ff;
   assign rsp_tlast  = out_last_ff;

endmodule

// ===== hw/rtl/bitvector_gate_evaluator.sv =====
// Top level of the bit-vector gate evaluator.
//
// Gates arrive on the req_ stream, one transfer each; results leave on the
// rsp_ stream, one transfer per gate, in order. tuser carries the action,
// tlast marks the last gate of a simulation step and is echoed on rsp_tlast.
// Load writes a whole wire word, read returns one; gate actions update the
// destination bits one at a time, so overlapping ranges propagate.
// Each transfer first has its offsets wrapped (reciprocal quotient,
// remainder, one correction). A gate then takes each bit in turn: source
// read, destination read, write on the single-write wire RAM. The result
// then goes to the output register and rsp_tvalid rises. One gate is in
// work at a time; after each one the sequencer returns to idle before it
// takes the next one. After reset the wire RAM is cleared one word per
// cycle, all WIRE_WORDS words of it, with req_tready low. A stalled result
// holds in the output register; a finished gate waits for it to drain
// before the next gate is taken.
module bitvector_gate_evaluator import bge_pkg::*; #(
   parameter int WIRE_WORDS = 1024,
   parameter int MAX_WIDTH  = 64
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_tvalid,
   output logic                 req_tready,
   // [15:0] src_a_offset, [31:16] src_b_offset, [47:32] dest_offset,
   // [54:48] bit_count, [118:55] word_data, [119] zero
   input  logic [119:0]         req_tdata,
   // [3:0] action
   input  logic [ACT_BITS-1:0]  req_tuser,
   input  logic                 req_tlast,
   output logic                 rsp_tvalid,
   input  logic                 rsp_tready,
   // [63:0] result_bits
   output logic [WORD_BITS-1:0] rsp_tdata,
   output logic                 rsp_tlast
);

   cmd_type    cmd;
   status_type status;

   bge_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .status     (status),
      .cmd        (cmd)
   );

   bge_datapath #(.WIRE_WORDS(WIRE_WORDS), .MAX_WIDTH(MAX_WIDTH)) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .status     (status),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast)
   );

`ifndef SYNTHESIS
   // one gate in work at a time
   a_one_gate: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready)
      else $error("gate taken while previous gate in work");

   // a result appears only after the sequencer left idle
   a_rsp_after_work: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_tvalid) |-> $past(!req_tready))
      else $error("result raised from idle");
`endif

endmodule
